### rtl/vector_stroke_text_generator_assert.svh
// Assertion macros for the vector stroke text generator.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef VECTOR_STROKE_TEXT_GENERATOR_ASSERT_SVH
`define VECTOR_STROKE_TEXT_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VSTG_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VSTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vstg_pkg.sv
// Shared constants, types and saturation helper for the stroke text generator.
// No dependencies; every other RTL file refers to it by scoped names.
package vstg_pkg;

    localparam int COORD_BITS = 16;
    localparam int SUM_W      = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int CODE_W     = 8;
    localparam int COLOUR_W   = 24;
    localparam int H_W        = 12;
    localparam int H3_W       = H_W + 2;
    localparam int U_W        = 5;
    localparam int DELTA_W    = 12;
    localparam int ROM_DEPTH  = 97;
    localparam int ADDR_W     = $clog2(ROM_DEPTH);
    localparam int MAX_SEGS   = 7;
    localparam int CNT_W      = $clog2(MAX_SEGS + 1);

    // u*3*H and u*H products
    localparam int PX_W       = 18;
    localparam int PY_W       = 17;

    // floor(n/100), floor(n/20), floor(n/5) by reciprocal multiply
    localparam int DIVX_MUL   = 335545;
    localparam int DIVX_SH    = 25;
    localparam int PRODX_W    = 37;
    localparam int DIVY_MUL   = 209716;
    localparam int DIVY_SH    = 22;
    localparam int PRODY_W    = 35;
    localparam int PITCH_MUL  = 26215;
    localparam int PITCH_SH   = 17;
    localparam int PRODP_W    = 29;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic [DELTA_W-1:0]           t_dval;

    typedef struct packed {
        logic [U_W-1:0] sx;
        logic [U_W-1:0] sy;
        logic [U_W-1:0] ex;
        logic [U_W-1:0] ey;
    } t_seg;

    typedef struct packed {
        logic valid;
        logic last;
    } t_seg_ctl;

    typedef struct packed {
        t_dval dx0;
        t_dval dy0;
        t_dval dx1;
        t_dval dy1;
    } t_delta;

    localparam t_sum SAT_HI =
        t_sum'({{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}});
    localparam t_sum SAT_LO = ~SAT_HI;

    function automatic t_coord sat_coord(input t_sum v);
        t_coord r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/vstg_if.sv
// Handshake interfaces: character requests in, line segment requests out.
// Depends on vstg_pkg for field widths.
interface vstg_char_if;
    logic                            valid;
    logic                            ready;
    logic [vstg_pkg::CODE_W-1:0]     char_code;
    logic                            string_start;
    logic signed [15:0]              origin_x;
    logic signed [15:0]              origin_y;
    logic [vstg_pkg::H_W-1:0]        char_height;
    logic [vstg_pkg::COLOUR_W-1:0]   colour_in;

    modport source (output valid, char_code, string_start, origin_x, origin_y,
                    char_height, colour_in, input ready);
    modport sink   (input valid, char_code, string_start, origin_x, origin_y,
                    char_height, colour_in, output ready);
endinterface

interface vstg_seg_if;
    logic                            valid;
    logic                            ready;
    vstg_pkg::t_coord                start_x;
    vstg_pkg::t_coord                start_y;
    vstg_pkg::t_coord                end_x;
    vstg_pkg::t_coord                end_y;
    logic [vstg_pkg::COLOUR_W-1:0]   line_colour;
    logic                            last_segment;

    modport source (output valid, start_x, start_y, end_x, end_y, line_colour,
                    last_segment, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, line_colour,
                    last_segment, output ready);
endinterface

### rtl/vstg_stroke_rom.sv
// Synchronous stroke ROM: one segment (four end coordinates in 1/20 cell) per entry.
// Depends on vstg_pkg; read data is registered.
module vstg_stroke_rom (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [vstg_pkg::ADDR_W-1:0] i_addr,
    output vstg_pkg::t_seg              o_seg
);

    vstg_pkg::t_seg r_seg;

    function automatic vstg_pkg::t_seg mk(input int a, input int b, input int c, input int d);
        return {vstg_pkg::U_W'(a), vstg_pkg::U_W'(b), vstg_pkg::U_W'(c), vstg_pkg::U_W'(d)};
    endfunction

    function automatic vstg_pkg::t_seg stroke_word(input logic [vstg_pkg::ADDR_W-1:0] a);
        vstg_pkg::t_seg w;
        unique case (a)
            // 0 / O
            7'd0:  w = mk(0, 0, 20, 0);
            7'd1:  w = mk(20, 0, 20, 20);
            7'd2:  w = mk(20, 20, 0, 20);
            7'd3:  w = mk(0, 20, 0, 0);
            // 1
            7'd4:  w = mk(10, 0, 10, 20);
            // 2
            7'd5:  w = mk(0, 0, 20, 0);
            7'd6:  w = mk(20, 0, 20, 10);
            7'd7:  w = mk(20, 10, 0, 10);
            7'd8:  w = mk(0, 10, 0, 20);
            7'd9:  w = mk(0, 20, 20, 20);
            // 3
            7'd10: w = mk(0, 0, 20, 0);
            7'd11: w = mk(20, 0, 20, 20);
            7'd12: w = mk(0, 10, 20, 10);
            7'd13: w = mk(0, 20, 20, 20);
            // 4
            7'd14: w = mk(0, 0, 0, 10);
            7'd15: w = mk(0, 10, 20, 10);
            7'd16: w = mk(20, 0, 20, 20);
            // 5 / S
            7'd17: w = mk(20, 0, 0, 0);
            7'd18: w = mk(0, 0, 0, 10);
            7'd19: w = mk(0, 10, 20, 10);
            7'd20: w = mk(20, 10, 20, 20);
            7'd21: w = mk(20, 20, 0, 20);
            // 6
            7'd22: w = mk(20, 0, 0, 0);
            7'd23: w = mk(0, 0, 0, 20);
            7'd24: w = mk(0, 20, 20, 20);
            7'd25: w = mk(20, 20, 20, 10);
            7'd26: w = mk(20, 10, 0, 10);
            // 7
            7'd27: w = mk(0, 0, 20, 0);
            7'd28: w = mk(20, 0, 20, 20);
            // 8
            7'd29: w = mk(0, 0, 20, 0);
            7'd30: w = mk(20, 0, 20, 20);
            7'd31: w = mk(0, 0, 0, 20);
            7'd32: w = mk(0, 10, 20, 10);
            7'd33: w = mk(0, 20, 20, 20);
            // 9
            7'd34: w = mk(0, 0, 20, 0);
            7'd35: w = mk(20, 0, 20, 20);
            7'd36: w = mk(0, 0, 0, 10);
            7'd37: w = mk(0, 10, 20, 10);
            // A
            7'd38: w = mk(0, 20, 10, 0);
            7'd39: w = mk(10, 0, 20, 20);
            7'd40: w = mk(3, 10, 17, 10);
            // B
            7'd41: w = mk(0, 0, 0, 20);
            7'd42: w = mk(0, 0, 12, 0);
            7'd43: w = mk(12, 0, 18, 5);
            7'd44: w = mk(18, 5, 12, 10);
            7'd45: w = mk(12, 10, 18, 15);
            7'd46: w = mk(18, 15, 12, 20);
            7'd47: w = mk(12, 20, 0, 20);
            // C
            7'd48: w = mk(20, 0, 0, 0);
            7'd49: w = mk(0, 0, 0, 20);
            7'd50: w = mk(0, 20, 20, 20);
            // D
            7'd51: w = mk(0, 0, 0, 20);
            7'd52: w = mk(0, 0, 14, 0);
            7'd53: w = mk(14, 0, 20, 6);
            7'd54: w = mk(20, 6, 20, 14);
            7'd55: w = mk(20, 14, 14, 20);
            7'd56: w = mk(14, 20, 0, 20);
            // E
            7'd57: w = mk(0, 0, 0, 20);
            7'd58: w = mk(0, 0, 20, 0);
            7'd59: w = mk(0, 10, 14, 10);
            7'd60: w = mk(0, 20, 20, 20);
            // F
            7'd61: w = mk(0, 0, 0, 20);
            7'd62: w = mk(0, 0, 20, 0);
            7'd63: w = mk(0, 10, 14, 10);
            // G
            7'd64: w = mk(20, 0, 0, 0);
            7'd65: w = mk(0, 0, 0, 20);
            7'd66: w = mk(0, 20, 20, 20);
            7'd67: w = mk(20, 20, 20, 10);
            7'd68: w = mk(10, 10, 20, 10);
            // H
            7'd69: w = mk(0, 0, 0, 20);
            7'd70: w = mk(20, 0, 20, 20);
            7'd71: w = mk(0, 10, 20, 10);
            // I
            7'd72: w = mk(0, 0, 20, 0);
            7'd73: w = mk(10, 0, 10, 20);
            7'd74: w = mk(0, 20, 20, 20);
            // M
            7'd75: w = mk(0, 20, 0, 0);
            7'd76: w = mk(0, 0, 10, 10);
            7'd77: w = mk(10, 10, 20, 0);
            7'd78: w = mk(20, 0, 20, 20);
            // P, and R with one more stroke
            7'd79: w = mk(0, 0, 0, 20);
            7'd80: w = mk(0, 0, 20, 0);
            7'd81: w = mk(20, 0, 20, 10);
            7'd82: w = mk(20, 10, 0, 10);
            7'd83: w = mk(10, 10, 20, 20);
            // T
            7'd84: w = mk(0, 0, 20, 0);
            7'd85: w = mk(10, 0, 10, 20);
            // V
            7'd86: w = mk(0, 0, 10, 20);
            7'd87: w = mk(10, 20, 20, 0);
            // Z
            7'd88: w = mk(0, 0, 20, 0);
            7'd89: w = mk(20, 0, 0, 20);
            7'd90: w = mk(0, 20, 20, 20);
            // #
            7'd91: w = mk(7, 0, 7, 20);
            7'd92: w = mk(13, 0, 13, 20);
            7'd93: w = mk(0, 7, 20, 7);
            7'd94: w = mk(0, 13, 20, 13);
            // .
            7'd95: w = mk(9, 18, 11, 20);
            // -
            7'd96: w = mk(0, 10, 20, 10);
            default: w = '0;
        endcase
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= stroke_word(i_addr);
        end
    end

    assign o_seg = r_seg;

endmodule

### rtl/vstg_seg_scale.sv
// Two-stage scaling pipe: ROM units times height, then exact divide by 100 or 20
// via reciprocal multiply. Depends on vstg_pkg.
module vstg_seg_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  vstg_pkg::t_seg_ctl          i_ctl,
    input  vstg_pkg::t_seg              i_seg,
    input  logic [vstg_pkg::H3_W-1:0]   i_h3,
    input  logic [vstg_pkg::H_W-1:0]    i_height,
    output vstg_pkg::t_seg_ctl          o_ctl,
    output vstg_pkg::t_delta            o_delta,
    output logic                        o_busy
);

    vstg_pkg::t_seg_ctl             r_ctl1;
    vstg_pkg::t_seg_ctl             r_ctl2;
    logic [vstg_pkg::PX_W-1:0]      r_px0;
    logic [vstg_pkg::PX_W-1:0]      r_px1;
    logic [vstg_pkg::PY_W-1:0]      r_py0;
    logic [vstg_pkg::PY_W-1:0]      r_py1;
    vstg_pkg::t_delta               r_delta;

    logic [vstg_pkg::PX_W-1:0]      n_px0;
    logic [vstg_pkg::PX_W-1:0]      n_px1;
    logic [vstg_pkg::PY_W-1:0]      n_py0;
    logic [vstg_pkg::PY_W-1:0]      n_py1;
    logic [vstg_pkg::PRODX_W-1:0]   w_qx0;
    logic [vstg_pkg::PRODX_W-1:0]   w_qx1;
    logic [vstg_pkg::PRODY_W-1:0]   w_qy0;
    logic [vstg_pkg::PRODY_W-1:0]   w_qy1;

    // stage 1: u*3H for x, u*H for y
    always_comb begin
        n_px0 = vstg_pkg::PX_W'(i_seg.sx) * vstg_pkg::PX_W'(i_h3);
        n_px1 = vstg_pkg::PX_W'(i_seg.ex) * vstg_pkg::PX_W'(i_h3);
        n_py0 = vstg_pkg::PY_W'(i_seg.sy) * vstg_pkg::PY_W'(i_height);
        n_py1 = vstg_pkg::PY_W'(i_seg.ey) * vstg_pkg::PY_W'(i_height);
    end

    // stage 2: floor(px/100), floor(py/20)
    always_comb begin
        w_qx0 = vstg_pkg::PRODX_W'(r_px0) * vstg_pkg::PRODX_W'(vstg_pkg::DIVX_MUL);
        w_qx1 = vstg_pkg::PRODX_W'(r_px1) * vstg_pkg::PRODX_W'(vstg_pkg::DIVX_MUL);
        w_qy0 = vstg_pkg::PRODY_W'(r_py0) * vstg_pkg::PRODY_W'(vstg_pkg::DIVY_MUL);
        w_qy1 = vstg_pkg::PRODY_W'(r_py1) * vstg_pkg::PRODY_W'(vstg_pkg::DIVY_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_step) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_px0         <= n_px0;
            r_px1         <= n_px1;
            r_py0         <= n_py0;
            r_py1         <= n_py1;
            r_delta.dx0   <= w_qx0[vstg_pkg::DIVX_SH +: vstg_pkg::DELTA_W];
            r_delta.dx1   <= w_qx1[vstg_pkg::DIVX_SH +: vstg_pkg::DELTA_W];
            r_delta.dy0   <= w_qy0[vstg_pkg::DIVY_SH +: vstg_pkg::DELTA_W];
            r_delta.dy1   <= w_qy1[vstg_pkg::DIVY_SH +: vstg_pkg::DELTA_W];
        end
    end

    assign o_ctl   = r_ctl2;
    assign o_delta = r_delta;
    assign o_busy  = r_ctl1.valid | r_ctl2.valid;

endmodule

### rtl/vector_stroke_text_generator.sv
// Top level: glyph sequencer, string context, stroke ROM and scaling pipe,
// output register. Depends on vstg_pkg, vstg_if, vstg_stroke_rom, vstg_seg_scale.
//
//   port     dir  kind                  moves
//   i_char   in   vstg_char_if.sink     one character request (code + string context)
//   o_seg    out  vstg_seg_if.source    one line segment request per glyph stroke
//
// A character with n strokes takes n ROM reads, one per cycle while o_seg does not
// stall, then a three-stage drain (ROM, multiply, divide) before the cursor advances.
// A character without a glyph skips the ROM reads and goes straight to the drain.
// i_char.ready is high only between characters. Reset is synchronous, active low,
// and clears the string context. A stalled o_seg freezes ROM and pipe; a new character
// may be taken while the last segment of the previous one still waits in the output register.
module vector_stroke_text_generator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vstg_char_if.sink       i_char,
    vstg_seg_if.source      o_seg
);

`include "vector_stroke_text_generator_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    typedef struct packed {
        logic                           hit;
        logic [vstg_pkg::ADDR_W-1:0]    first;
        logic [vstg_pkg::CNT_W-1:0]     count;
    } t_glyph;

    function automatic t_glyph mkg(input int first, input int count);
        return '{hit: 1'b1, first: vstg_pkg::ADDR_W'(first), count: vstg_pkg::CNT_W'(count)};
    endfunction

    function automatic t_glyph glyph_lookup(input logic [vstg_pkg::CODE_W-1:0] code);
        t_glyph g;
        unique case (code)
            8'h30: g = mkg(0, 4);    // '0'
            8'h31: g = mkg(4, 1);
            8'h32: g = mkg(5, 5);
            8'h33: g = mkg(10, 4);
            8'h34: g = mkg(14, 3);
            8'h35: g = mkg(17, 5);
            8'h36: g = mkg(22, 5);
            8'h37: g = mkg(27, 2);
            8'h38: g = mkg(29, 5);
            8'h39: g = mkg(34, 4);   // '9'
            8'h41: g = mkg(38, 3);   // 'A'
            8'h42: g = mkg(41, 7);
            8'h43: g = mkg(48, 3);
            8'h44: g = mkg(51, 6);
            8'h45: g = mkg(57, 4);
            8'h46: g = mkg(61, 3);
            8'h47: g = mkg(64, 5);
            8'h48: g = mkg(69, 3);
            8'h49: g = mkg(72, 3);   // 'I'
            8'h4D: g = mkg(75, 4);   // 'M'
            8'h4F: g = mkg(0, 4);    // 'O' shares '0'
            8'h50: g = mkg(79, 4);   // 'P'
            8'h52: g = mkg(79, 5);   // 'R'
            8'h53: g = mkg(17, 5);   // 'S' shares '5'
            8'h54: g = mkg(84, 2);   // 'T'
            8'h56: g = mkg(86, 2);   // 'V'
            8'h5A: g = mkg(88, 3);   // 'Z'
            8'h23: g = mkg(91, 4);   // '#'
            8'h2E: g = mkg(95, 1);   // '.'
            8'h2D: g = mkg(96, 1);   // '-'
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic vstg_pkg::t_coord add_sat(input vstg_pkg::t_coord base,
                                                 input vstg_pkg::t_dval d);
        return vstg_pkg::sat_coord(vstg_pkg::t_sum'(base) + vstg_pkg::t_sum'(d));
    endfunction

    t_state                             r_state;
    logic [vstg_pkg::ADDR_W-1:0]        r_addr;
    logic [vstg_pkg::CNT_W-1:0]         r_left;
    vstg_pkg::t_seg_ctl                 r_s0;

    vstg_pkg::t_coord                   r_cursor;
    vstg_pkg::t_coord                   r_base;
    logic [vstg_pkg::H_W-1:0]           r_height;
    logic [vstg_pkg::H3_W-1:0]          r_h3;
    vstg_pkg::t_dval                    r_pitch;
    logic [vstg_pkg::COLOUR_W-1:0]      r_colour;

    logic                               r_out_valid;
    vstg_pkg::t_coord                   r_sx;
    vstg_pkg::t_coord                   r_sy;
    vstg_pkg::t_coord                   r_ex;
    vstg_pkg::t_coord                   r_ey;
    logic [vstg_pkg::COLOUR_W-1:0]      r_out_colour;
    logic                               r_out_last;

    logic                               w_in_acc;
    logic                               w_step;
    logic                               w_issue;
    logic                               w_busy;
    logic                               w_pipe_busy;
    t_glyph                             w_glyph;
    logic [vstg_pkg::PRODP_W-1:0]       w_pitch_prod;
    vstg_pkg::t_seg                     w_rom_seg;
    vstg_pkg::t_seg_ctl                 w_ctl2;
    vstg_pkg::t_delta                   w_delta;

    assign w_in_acc     = i_char.valid && i_char.ready;
    assign i_char.ready = (r_state == S_IDLE);
    // whole pipe moves only when the output register can take a new request
    assign w_step       = !r_out_valid || o_seg.ready;
    assign w_issue      = (r_state == S_RUN) && w_step;
    assign w_busy       = r_s0.valid || w_pipe_busy;
    assign w_glyph      = glyph_lookup(i_char.char_code);
    assign w_pitch_prod = vstg_pkg::PRODP_W'({i_char.char_height, 2'b00})
                        * vstg_pkg::PRODP_W'(vstg_pkg::PITCH_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_left  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_addr  <= w_glyph.first;
                        r_left  <= w_glyph.count;
                        r_state <= w_glyph.hit ? S_RUN : S_DRAIN;
                    end
                end
                S_RUN: begin
                    if (w_step) begin
                        r_addr <= r_addr + vstg_pkg::ADDR_W'(1);
                        r_left <= r_left - vstg_pkg::CNT_W'(1);
                        if (r_left == vstg_pkg::CNT_W'(1)) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!w_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
        end else if (w_step) begin
            r_s0 <= '{valid: w_issue, last: (r_left == vstg_pkg::CNT_W'(1))};
        end
    end

    // string context: latch on string start, advance cursor once the glyph has left the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_base   <= '0;
            r_height <= '0;
            r_h3     <= '0;
            r_pitch  <= '0;
            r_colour <= '0;
        end else if (w_in_acc && i_char.string_start) begin
            r_cursor <= vstg_pkg::sat_coord(vstg_pkg::t_sum'(i_char.origin_x));
            r_base   <= vstg_pkg::sat_coord(vstg_pkg::t_sum'(i_char.origin_y));
            r_height <= i_char.char_height;
            r_h3     <= vstg_pkg::H3_W'({2'b00, i_char.char_height})
                      + vstg_pkg::H3_W'({i_char.char_height, 1'b0});
            r_pitch  <= w_pitch_prod[vstg_pkg::PITCH_SH +: vstg_pkg::DELTA_W];
            r_colour <= i_char.colour_in;
        end else if (r_state == S_DRAIN && !w_busy) begin
            r_cursor <= add_sat(r_cursor, r_pitch);
        end
    end

    vstg_stroke_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (w_step),
        .i_addr (r_addr),
        .o_seg  (w_rom_seg)
    );

    vstg_seg_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_ctl    (r_s0),
        .i_seg    (w_rom_seg),
        .i_h3     (r_h3),
        .i_height (r_height),
        .o_ctl    (w_ctl2),
        .o_delta  (w_delta),
        .o_busy   (w_pipe_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_ctl2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_ctl2.valid) begin
            r_sx         <= add_sat(r_cursor, w_delta.dx0);
            r_sy         <= add_sat(r_base, w_delta.dy0);
            r_ex         <= add_sat(r_cursor, w_delta.dx1);
            r_ey         <= add_sat(r_base, w_delta.dy1);
            r_out_colour <= r_colour;
            r_out_last   <= w_ctl2.last;
        end
    end

    assign o_seg.valid        = r_out_valid;
    assign o_seg.start_x      = r_sx;
    assign o_seg.start_y      = r_sy;
    assign o_seg.end_x        = r_ex;
    assign o_seg.end_y        = r_ey;
    assign o_seg.line_colour  = r_out_colour;
    assign o_seg.last_segment = r_out_last;

    `VSTG_ASSERT_HOLDS(a_idle_empty, i_clk, i_rst_n, r_state == S_IDLE, !w_busy, "pipe busy while idle")
    `VSTG_ASSERT_HOLDS(a_run_left, i_clk, i_rst_n, r_state == S_RUN, r_left != '0, "run with no strokes left")
    `VSTG_ASSERT_NEXT(a_last_drain, i_clk, i_rst_n, w_issue && r_left == vstg_pkg::CNT_W'(1), r_state == S_DRAIN, "no drain after last stroke")
    `VSTG_ASSERT_NEXT(a_cursor_hold, i_clk, i_rst_n, !w_in_acc && r_state != S_DRAIN, $stable(r_cursor), "cursor moved mid glyph")

endmodule

### tb/sv/vstg_stroke_checker.sv
// Segment checker for the vector stroke text generator: watches both channels,
// predicts each character's line segments and compares them in order.
// Depends on vstg_pkg and the vstg_char_if / vstg_seg_if interfaces.
`timescale 1ns / 1ps

module vstg_stroke_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vstg_char_if  char_mon,
    vstg_seg_if   seg_mon,
    output int    o_fail_count,
    output int    o_pending
);
    import vstg_pkg::*;

    localparam int     REPORT_CAP = 100;
    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;

    typedef struct {
        t_coord              sx;
        t_coord              sy;
        t_coord              ex;
        t_coord              ey;
        logic [COLOUR_W-1:0] ink;
        logic                last;
    } stroke_t;

    // Stroke ends in 1/20 cell units: x0, y0, x1, y1.
    int stroke_rom [0:96][0:3] = '{
        '{0,0,20,0},   '{20,0,20,20},  '{20,20,0,20},  '{0,20,0,0},
        '{10,0,10,20},
        '{0,0,20,0},   '{20,0,20,10},  '{20,10,0,10},  '{0,10,0,20},  '{0,20,20,20},
        '{0,0,20,0},   '{20,0,20,20},  '{0,10,20,10},  '{0,20,20,20},
        '{0,0,0,10},   '{0,10,20,10},  '{20,0,20,20},
        '{20,0,0,0},   '{0,0,0,10},    '{0,10,20,10},  '{20,10,20,20}, '{20,20,0,20},
        '{20,0,0,0},   '{0,0,0,20},    '{0,20,20,20},  '{20,20,20,10}, '{20,10,0,10},
        '{0,0,20,0},   '{20,0,20,20},
        '{0,0,20,0},   '{20,0,20,20},  '{0,0,0,20},    '{0,10,20,10},  '{0,20,20,20},
        '{0,0,20,0},   '{20,0,20,20},  '{0,0,0,10},    '{0,10,20,10},
        '{0,20,10,0},  '{10,0,20,20},  '{3,10,17,10},
        '{0,0,0,20},   '{0,0,12,0},    '{12,0,18,5},   '{18,5,12,10},  '{12,10,18,15},
        '{18,15,12,20},'{12,20,0,20},
        '{20,0,0,0},   '{0,0,0,20},    '{0,20,20,20},
        '{0,0,0,20},   '{0,0,14,0},    '{14,0,20,6},   '{20,6,20,14},  '{20,14,14,20},
        '{14,20,0,20},
        '{0,0,0,20},   '{0,0,20,0},    '{0,10,14,10},  '{0,20,20,20},
        '{0,0,0,20},   '{0,0,20,0},    '{0,10,14,10},
        '{20,0,0,0},   '{0,0,0,20},    '{0,20,20,20},  '{20,20,20,10}, '{10,10,20,10},
        '{0,0,0,20},   '{20,0,20,20},  '{0,10,20,10},
        '{0,0,20,0},   '{10,0,10,20},  '{0,20,20,20},
        '{0,20,0,0},   '{0,0,10,10},   '{10,10,20,0},  '{20,0,20,20},
        '{0,0,0,20},   '{0,0,20,0},    '{20,0,20,10},  '{20,10,0,10},  '{10,10,20,20},
        '{0,0,20,0},   '{10,0,10,20},
        '{0,0,10,20},  '{10,20,20,0},
        '{0,0,20,0},   '{20,0,0,20},   '{0,20,20,20},
        '{7,0,7,20},   '{13,0,13,20},  '{0,7,20,7},    '{0,13,20,13},
        '{9,18,11,20},
        '{0,10,20,10}
    };

    stroke_t             strokes_due[$];
    t_coord              pen_x;
    t_coord              pen_y;
    logic [H_W-1:0]      glyph_h;
    logic [COLOUR_W-1:0] ink;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        pen_x        = '0;
        pen_y        = '0;
        glyph_h      = '0;
        ink          = '0;
    end

    function automatic t_coord clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return t_coord'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            return t_coord'(COORD_MIN);
        end
        return t_coord'(v);
    endfunction

    function automatic void glyph_span(input logic [CODE_W-1:0] code,
                                       output int first, output int count);
        case (code)
            "0", "O": begin first = 0;  count = 4; end
            "1":      begin first = 4;  count = 1; end
            "2":      begin first = 5;  count = 5; end
            "3":      begin first = 10; count = 4; end
            "4":      begin first = 14; count = 3; end
            "5", "S": begin first = 17; count = 5; end
            "6":      begin first = 22; count = 5; end
            "7":      begin first = 27; count = 2; end
            "8":      begin first = 29; count = 5; end
            "9":      begin first = 34; count = 4; end
            "A":      begin first = 38; count = 3; end
            "B":      begin first = 41; count = 7; end
            "C":      begin first = 48; count = 3; end
            "D":      begin first = 51; count = 6; end
            "E":      begin first = 57; count = 4; end
            "F":      begin first = 61; count = 3; end
            "G":      begin first = 64; count = 5; end
            "H":      begin first = 69; count = 3; end
            "I":      begin first = 72; count = 3; end
            "M":      begin first = 75; count = 4; end
            "P":      begin first = 79; count = 4; end
            "R":      begin first = 79; count = 5; end
            "T":      begin first = 84; count = 2; end
            "V":      begin first = 86; count = 2; end
            "Z":      begin first = 88; count = 3; end
            "#":      begin first = 91; count = 4; end
            ".":      begin first = 95; count = 1; end
            "-":      begin first = 96; count = 1; end
            default:  begin first = 0;  count = 0; end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fail_count < REPORT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // Latch the string context first, then lay out the glyph at the pen.
    task automatic draw_char(input logic [CODE_W-1:0] code, input logic start,
                             input logic signed [15:0] ox, input logic signed [15:0] oy,
                             input logic [H_W-1:0] h, input logic [COLOUR_W-1:0] col);
        int      first;
        int      count;
        longint  hv;
        stroke_t s;
        if (start) begin
            pen_x   = clamp_coord(longint'(ox));
            pen_y   = clamp_coord(longint'(oy));
            glyph_h = h;
            ink     = col;
        end
        hv = longint'(glyph_h);
        glyph_span(code, first, count);
        for (int k = 0; k < count; k++) begin
            s.sx   = clamp_coord(longint'(pen_x) + (stroke_rom[first+k][0] * 3 * hv) / 100);
            s.sy   = clamp_coord(longint'(pen_y) + (stroke_rom[first+k][1] * hv) / 20);
            s.ex   = clamp_coord(longint'(pen_x) + (stroke_rom[first+k][2] * 3 * hv) / 100);
            s.ey   = clamp_coord(longint'(pen_y) + (stroke_rom[first+k][3] * hv) / 20);
            s.ink  = ink;
            s.last = (k == count - 1);
            strokes_due.push_back(s);
        end
        // advance even when the code has no glyph
        pen_x = clamp_coord(longint'(pen_x) + (4 * hv) / 5);
    endtask

    task automatic check_segment();
        stroke_t want;
        if (strokes_due.size() == 0) begin
            report_mismatch($sformatf("segment (%0d,%0d)-(%0d,%0d) with none expected",
                seg_mon.start_x, seg_mon.start_y, seg_mon.end_x, seg_mon.end_y));
        end else begin
            want = strokes_due.pop_front();
            if (seg_mon.start_x !== want.sx)
                report_mismatch($sformatf("start_x got %0d want %0d", seg_mon.start_x, want.sx));
            if (seg_mon.start_y !== want.sy)
                report_mismatch($sformatf("start_y got %0d want %0d", seg_mon.start_y, want.sy));
            if (seg_mon.end_x !== want.ex)
                report_mismatch($sformatf("end_x got %0d want %0d", seg_mon.end_x, want.ex));
            if (seg_mon.end_y !== want.ey)
                report_mismatch($sformatf("end_y got %0d want %0d", seg_mon.end_y, want.ey));
            if (seg_mon.line_colour !== want.ink)
                report_mismatch($sformatf("line_colour got %06h want %06h",
                    seg_mon.line_colour, want.ink));
            if (seg_mon.last_segment !== want.last)
                report_mismatch($sformatf("last_segment got %b want %b",
                    seg_mon.last_segment, want.last));
        end
    endtask

    // Compare before predicting: a segment taken in the same cycle as a new
    // character always belongs to an older one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pen_x   = '0;
            pen_y   = '0;
            glyph_h = '0;
            ink     = '0;
        end else begin
            if (seg_mon.valid === 1'b1 && seg_mon.ready === 1'b1) begin
                check_segment();
            end
            if (char_mon.valid === 1'b1 && char_mon.ready === 1'b1) begin
                draw_char(char_mon.char_code, char_mon.string_start, char_mon.origin_x,
                          char_mon.origin_y, char_mon.char_height, char_mon.colour_in);
            end
        end
        o_pending = strokes_due.size();
    end

endmodule

### tb/sv/tb_top.sv
// Top of the stroke text generator bench: clock, reset, character requests,
// segment back-pressure, stall watchdog and verdict. Checking lives in
// vstg_stroke_checker; depends on vstg_pkg, the interfaces and the RTL top.
`timescale 1ns / 1ps

module tb_top;
    import vstg_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 90;

    logic  i_clk;
    logic  i_rst_n;
    int    fail_count;
    int    pending;
    int    tx_idle_pct;
    int    rx_idle_pct;
    logic  hold_req;
    int    stall_cycles = 0;
    string glyph_codes  = "0123456789ABCDEFGHIMOPRSTVZ#.-";

    vstg_char_if char_bus();
    vstg_seg_if  seg_bus();

    vector_stroke_text_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_seg   (seg_bus)
    );

    vstg_stroke_checker u_stroke_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .char_mon     (char_bus),
        .seg_mon      (seg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Segment sink: random back-pressure, or a long hold-off when asked.
    initial begin : seg_sink
        int hold_left;
        hold_left     = 0;
        seg_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                seg_bus.ready = 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req      = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                seg_bus.ready = 1'b0;
            end else begin
                seg_bus.ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((char_bus.valid === 1'b1 && char_bus.ready === 1'b1) ||
            (seg_bus.valid === 1'b1 && seg_bus.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL vector_stroke_text_generator");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one character request; called and returns at a falling edge.
    task automatic send_char(input logic [CODE_W-1:0] code, input logic start,
                             input logic [15:0] ox, input logic [15:0] oy,
                             input logic [H_W-1:0] h, input logic [COLOUR_W-1:0] col);
        while ($urandom_range(99) < tx_idle_pct) begin
            char_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid        = 1'b1;
        char_bus.char_code    = code;
        char_bus.string_start = start;
        char_bus.origin_x     = ox;
        char_bus.origin_y     = oy;
        char_bus.char_height  = h;
        char_bus.colour_in    = col;
        do @(posedge i_clk); while (char_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(99) < 85) begin
            return glyph_codes[$urandom_range(glyph_codes.len() - 1)];
        end
        return CODE_W'($urandom_range(255));
    endfunction

    // Half full range, half near the middle of the screen.
    function automatic logic [15:0] pick_origin();
        if ($urandom_range(1)) begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(4000)) - 2000);
    endfunction

    function automatic logic [H_W-1:0] pick_height();
        if ($urandom_range(1)) begin
            return H_W'($urandom_range(4095));
        end
        return H_W'($urandom_range(320));
    endfunction

    // Mostly whole strings (start request then plain characters), some noise.
    task automatic send_strings(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_char(CODE_W'($urandom_range(255)), 1'($urandom_range(1)), pick_origin(),
                          pick_origin(), pick_height(), COLOUR_W'($urandom));
                sent++;
            end else begin
                len = $urandom_range(8, 1);
                send_char(pick_code(), 1'b1, pick_origin(), pick_origin(), pick_height(),
                          COLOUR_W'($urandom));
                sent++;
                for (int k = 1; k < len; k++) begin
                    send_char(pick_code(), 1'b0, 16'($urandom), 16'($urandom),
                              H_W'($urandom), COLOUR_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Stop offering and hold until every predicted segment has come out.
    task automatic wait_drained();
        char_bus.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n               = 1'b0;
        hold_req              = 1'b0;
        tx_idle_pct           = 32;
        rx_idle_pct           = 62;
        char_bus.valid        = 1'b0;
        char_bus.char_code    = '0;
        char_bus.string_start = 1'b0;
        char_bus.origin_x     = '0;
        char_bus.origin_y     = '0;
        char_bus.char_height  = '0;
        char_bus.colour_in    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // before any string start: everything collapses onto the origin
        send_char("8", 1'b0, 16'h1234, 16'h4321, 12'hfff, 24'hffffff);
        // tallest glyph at full height, then run the pen across the row
        send_char("B", 1'b1, 16'h0000, 16'h0000, 12'hfff, 24'hffffff);
        send_char("R", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("#", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char(".", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("-", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("M", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("O", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("S", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        // upper clamp on every end, then lower corner with zero height
        send_char("0", 1'b1, 16'h7fff, 16'h7fff, 12'hfff, 24'h000000);
        send_char("Z", 1'b1, 16'h8000, 16'h8000, 12'h000, 24'h5a5a5a);
        // glyphless start still latches the context
        send_char("W", 1'b1, 16'h8000, 16'h0100, 12'hfff, 24'ha5a5a5);
        send_char("A", 1'b0, 16'hffff, 16'hffff, 12'hfff, 24'hffffff);
        send_char(8'h00, 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char(8'hff, 1'b0, 16'hffff, 16'hffff, 12'hfff, 24'hffffff);
        send_char(8'h80, 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("a", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("P", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        // pen runs into the right edge and sticks there
        send_char("1", 1'b1, 16'd30000, 16'h0000, 12'hfff, 24'h123456);
        send_char("1", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);
        send_char("1", 1'b0, 16'h0000, 16'h0000, 12'h000, 24'h000000);

        send_strings(60);

        tx_idle_pct = 62;
        rx_idle_pct = 32;
        send_strings(60);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_strings(25);

        // long sink hold-off while requests keep coming, so the block backs up
        hold_req = 1'b1;
        send_char("B", 1'b1, pick_origin(), pick_origin(), pick_height(), COLOUR_W'($urandom));
        repeat (9) begin
            send_char(pick_code(), 1'b0, 16'($urandom), 16'($urandom), H_W'($urandom),
                      COLOUR_W'($urandom));
        end
        wait_drained();

        send_strings(30);
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS vector_stroke_text_generator");
        end else begin
            $display("FAIL vector_stroke_text_generator");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/vstg_pkg.sv
rtl/vstg_if.sv
rtl/vstg_stroke_rom.sv
rtl/vstg_seg_scale.sv
rtl/vector_stroke_text_generator.sv
tb/sv/vstg_stroke_checker.sv
tb/sv/tb_top.sv
